>>> design/matrix3_inverse_defines.svh
// Assertion macros for the 3x3 matrix inverse.
// Needs clk and rst in the scope where a macro is used.
`ifndef MATRIX3_INVERSE_DEFINES_SVH
`define MATRIX3_INVERSE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define M3INV_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define M3INV_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
    else $error(msg);

`endif

>>> design/m3inv_pkg.sv
// Package for the 3x3 matrix inverse: request and result types and defaults.
// No dependencies.
package m3inv_pkg;

  // Field widths of the request and result.
  localparam int FIELD_W = 16;
  localparam int OUT_W   = 32;

  // Default arithmetic parameters.
  localparam int ELEM_WIDTH_DEF = 16;
  localparam int IN_FRAC_DEF    = 8;
  localparam int OUT_FRAC_DEF   = 16;

  // One request: a matrix in row-major order.
  typedef struct packed {
    logic signed [FIELD_W-1:0] a00;
    logic signed [FIELD_W-1:0] a01;
    logic signed [FIELD_W-1:0] a02;
    logic signed [FIELD_W-1:0] a10;
    logic signed [FIELD_W-1:0] a11;
    logic signed [FIELD_W-1:0] a12;
    logic signed [FIELD_W-1:0] a20;
    logic signed [FIELD_W-1:0] a21;
    logic signed [FIELD_W-1:0] a22;
  } req_t;

  // One result: the inverse in row-major order and two flags.
  typedef struct packed {
    logic signed [OUT_W-1:0] inv00;
    logic signed [OUT_W-1:0] inv01;
    logic signed [OUT_W-1:0] inv02;
    logic signed [OUT_W-1:0] inv10;
    logic signed [OUT_W-1:0] inv11;
    logic signed [OUT_W-1:0] inv12;
    logic signed [OUT_W-1:0] inv20;
    logic signed [OUT_W-1:0] inv21;
    logic signed [OUT_W-1:0] inv22;
    logic                    singular;
    logic                    saturated;
  } res_t;

endpackage

>>> design/matrix3_inverse.sv
// Top level of the 3x3 matrix inverse: adjugate over determinant, fully pipelined.
// Depends on m3inv_pkg and matrix3_inverse_defines.svh.
//
//  channel   ports             direction  handshake
//  request   start, busy, mat  in         taken when start is high and busy low
//  result    done, inv         out        shown for one cycle while done is high
//
// One request may enter in every cycle; busy is always low.
// Six stages form products, cofactors and the determinant, 32 restoring steps
// (one per stage) divide, and one stage saturates.
// Synchronous reset clears only the valid bits; results leave as they arrive.
`include "matrix3_inverse_defines.svh"

module matrix3_inverse #(
  parameter int ELEM_WIDTH = m3inv_pkg::ELEM_WIDTH_DEF,
  parameter int IN_FRAC    = m3inv_pkg::IN_FRAC_DEF,
  parameter int OUT_FRAC   = m3inv_pkg::OUT_FRAC_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  m3inv_pkg::req_t  mat,
  output logic             done,
  output m3inv_pkg::res_t  inv
);

  localparam int EW   = ELEM_WIDTH;
  localparam int FW   = m3inv_pkg::FIELD_W;
  localparam int QW   = m3inv_pkg::OUT_W;
  localparam int PW   = 2 * EW;
  localparam int CW   = 2 * EW + 1;
  localparam int DPW  = EW + CW;
  localparam int DWS  = DPW + 2;
  localparam int DW   = DWS - 1;
  localparam int SH   = IN_FRAC + OUT_FRAC;
  localparam int NW   = CW + SH;
  localparam int RW   = DW + QW;
  localparam int CMPW = ((NW > RW) ? NW : RW) + 1;
  localparam int PRE  = 6;
  localparam int LAT  = PRE + QW + 1;

  assign busy = 1'b0;

  // Valid bits travel with the data.
  logic [LAT-1:0] vpipe;
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[LAT-2:0], start};
    end
  end
  assign done = vpipe[LAT-1];

  // Raw request fields in row-major order.
  logic [FW-1:0] raw [9];
  assign raw[0] = mat.a00;
  assign raw[1] = mat.a01;
  assign raw[2] = mat.a02;
  assign raw[3] = mat.a10;
  assign raw[4] = mat.a11;
  assign raw[5] = mat.a12;
  assign raw[6] = mat.a20;
  assign raw[7] = mat.a21;
  assign raw[8] = mat.a22;

  // Stage 1: elements at the working width.
  logic signed [EW-1:0] m_in [9];
  logic signed [EW-1:0] m1   [9];
  for (genvar k = 0; k < 9; k++) begin : g_ext
    if (EW <= FW) begin : g_narrow
      assign m_in[k] = $signed(raw[k][EW-1:0]);
    end else begin : g_wide
      assign m_in[k] = $signed({{(EW-FW){1'b0}}, raw[k]});
    end
  end
  always_ff @(posedge clk) begin
    m1 <= m_in;
  end

  // Stage 2: the two products of every 2x2 minor.
  logic signed [PW-1:0] p1 [3][3];
  logic signed [PW-1:0] p2 [3][3];
  logic signed [EW-1:0] m2 [3];
  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      localparam int R1 = (i + 1) % 3;
      localparam int R2 = (i + 2) % 3;
      localparam int C1 = (j + 1) % 3;
      localparam int C2 = (j + 2) % 3;
      always_ff @(posedge clk) begin
        p1[i][j] <= m1[R1*3+C1] * m1[R2*3+C2];
        p2[i][j] <= m1[R1*3+C2] * m1[R2*3+C1];
      end
    end
  end
  always_ff @(posedge clk) begin
    m2 <= '{m1[0], m1[1], m1[2]};
  end

  // Stage 3: signed cofactors.
  logic signed [CW-1:0] cof3 [3][3];
  logic signed [EW-1:0] m3   [3];
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        cof3[i][j] <= CW'(p1[i][j]) - CW'(p2[i][j]);
      end
    end
    m3 <= m2;
  end

  // Stage 4: first-row terms of the determinant.
  logic signed [DPW-1:0] dp   [3];
  logic signed [CW-1:0]  cof4 [3][3];
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      dp[j] <= m3[j] * cof3[0][j];
    end
    cof4 <= cof3;
  end

  // Stage 5: determinant.
  logic signed [DWS-1:0] det5;
  logic signed [CW-1:0]  cof5 [3][3];
  always_ff @(posedge clk) begin
    det5 <= DWS'(dp[0]) + DWS'(dp[1]) + DWS'(dp[2]);
    cof5 <= cof4;
  end

  // Divider pipeline storage; index 0 is the loaded stage.
  logic [DW-1:0] rem  [QW+1][9];
  logic [QW-1:0] low  [QW+1][9];
  logic          neg  [QW+1][9];
  logic          ovf  [QW+1][9];
  logic [DW-1:0] dmag [QW+1];
  logic          zr   [QW+1];

  // Stage 6: magnitudes, signs and the overflow test, then load the divider.
  logic          det_neg;
  logic [DW-1:0] dmag_c;
  assign det_neg = det5[DWS-1];
  assign dmag_c  = DW'(det_neg ? -det5 : det5);

  for (genvar k = 0; k < 9; k++) begin : g_load
    // Element (i, j) of the inverse uses cofactor (j, i).
    localparam int I = k / 3;
    localparam int J = k % 3;
    logic              cneg;
    logic [CW-1:0]     cmag;
    logic [CMPW-1:0]   numw;
    logic [CMPW-1:0]   dlim;
    assign cneg = cof5[J][I][CW-1];
    assign cmag = CW'(cneg ? -cof5[J][I] : cof5[J][I]);
    assign numw = CMPW'(cmag) << SH;
    assign dlim = CMPW'(dmag_c) << QW;
    always_ff @(posedge clk) begin
      rem[0][k] <= numw[RW-1:QW];
      low[0][k] <= numw[QW-1:0];
      neg[0][k] <= cneg ^ det_neg;
      ovf[0][k] <= numw >= dlim;
    end
  end
  always_ff @(posedge clk) begin
    dmag[0] <= dmag_c;
    zr[0]   <= (det5 == '0);
  end

  // Restoring division: one quotient bit per stage.
  for (genvar s = 0; s < QW; s++) begin : g_div
    for (genvar k = 0; k < 9; k++) begin : g_lane
      logic [DW:0] r2;
      logic [DW:0] diff;
      logic        ge;
      assign r2   = {rem[s][k], low[s][k][QW-1]};
      assign diff = r2 - {1'b0, dmag[s]};
      assign ge   = r2 >= {1'b0, dmag[s]};
      always_ff @(posedge clk) begin
        rem[s+1][k] <= ge ? diff[DW-1:0] : r2[DW-1:0];
        low[s+1][k] <= {low[s][k][QW-2:0], ge};
        neg[s+1][k] <= neg[s][k];
        ovf[s+1][k] <= ovf[s][k];
      end
    end
    always_ff @(posedge clk) begin
      dmag[s+1] <= dmag[s];
      zr[s+1]   <= zr[s];
    end
  end

  // Final stage: clip to 32 bits, apply the sign, handle a zero determinant.
  logic [QW-1:0] elem [9];
  logic [8:0]    clip;
  for (genvar k = 0; k < 9; k++) begin : g_sat
    logic [QW-1:0] lim;
    logic [QW-1:0] mag;
    assign lim     = neg[QW][k] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    assign clip[k] = ovf[QW][k] || (low[QW][k] > lim);
    assign mag     = clip[k] ? lim : low[QW][k];
    assign elem[k] = zr[QW] ? '0 : (neg[QW][k] ? -mag : mag);
  end

  m3inv_pkg::res_t res_next;
  always_comb begin
    res_next.inv00     = elem[0];
    res_next.inv01     = elem[1];
    res_next.inv02     = elem[2];
    res_next.inv10     = elem[3];
    res_next.inv11     = elem[4];
    res_next.inv12     = elem[5];
    res_next.inv20     = elem[6];
    res_next.inv21     = elem[7];
    res_next.inv22     = elem[8];
    res_next.singular  = zr[QW];
    res_next.saturated = !zr[QW] && (|clip);
  end

  always_ff @(posedge clk) begin
    inv <= res_next;
  end

  // Checks on latency and on the singular case.
  `M3INV_ASSERT_NXT(a_latency, start, ##(LAT-1) done, "result missing after latency")
  `M3INV_ASSERT_IMP(a_origin, done, $past(start, LAT), "result without a request")
  `M3INV_ASSERT_IMP(a_singular, done && inv.singular, (!inv.saturated && inv.inv00 == '0 && inv.inv11 == '0 && inv.inv22 == '0), "singular result not cleared")

endmodule

>>> dv/matrix3_inverse_tb.sv
// Testbench for the 3x3 matrix inverse: directed table, then random matrices.
// Depends on m3inv_pkg and the matrix3_inverse top level.
module matrix3_inverse_tb;

  localparam int PIPE_DEPTH = 39;
  localparam int SHIFT      = m3inv_pkg::IN_FRAC_DEF + m3inv_pkg::OUT_FRAC_DEF;
  localparam int N_RANDOM   = 1500;

  logic            clk;
  logic            rst;
  logic            start;
  logic            busy;
  m3inv_pkg::req_t mat;
  logic            done;
  m3inv_pkg::res_t inv;

  matrix3_inverse uut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .mat   (mat),
    .done  (done),
    .inv   (inv)
  );

  m3inv_pkg::res_t expected_inverses[$];
  int              mismatch_count;
  bit              failed;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Elements as a signed ELEM_WIDTH value, widened to 128 bits.
  function automatic logic signed [127:0] elem_value(logic [m3inv_pkg::FIELD_W-1:0] raw);
    logic signed [m3inv_pkg::ELEM_WIDTH_DEF-1:0] narrow;
    narrow = raw[m3inv_pkg::ELEM_WIDTH_DEF-1:0];
    return 128'(narrow);
  endfunction

  // Adjugate over determinant, each element truncated toward zero and clipped.
  function automatic m3inv_pkg::res_t invert_matrix(m3inv_pkg::req_t m);
    logic signed [127:0]        e[3][3];
    logic signed [127:0]        cof[3][3];
    logic signed [127:0]        det;
    logic signed [127:0]        num;
    logic        [127:0]        quo;
    logic        [127:0]        lim;
    logic [m3inv_pkg::OUT_W-1:0] elems[9];
    logic                       neg;
    logic                       sat;
    m3inv_pkg::res_t            r;
    e[0][0] = elem_value(m.a00); e[0][1] = elem_value(m.a01); e[0][2] = elem_value(m.a02);
    e[1][0] = elem_value(m.a10); e[1][1] = elem_value(m.a11); e[1][2] = elem_value(m.a12);
    e[2][0] = elem_value(m.a20); e[2][1] = elem_value(m.a21); e[2][2] = elem_value(m.a22);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        cof[i][j] = e[(i+1)%3][(j+1)%3] * e[(i+2)%3][(j+2)%3]
                  - e[(i+1)%3][(j+2)%3] * e[(i+2)%3][(j+1)%3];
      end
    end
    det = e[0][0] * cof[0][0] + e[0][1] * cof[0][1] + e[0][2] * cof[0][2];
    r = '0;
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        num = cof[j][i] <<< SHIFT;
        neg = num[127] ^ det[127];
        quo = (num[127] ? -num : num) / (det[127] ? -det : det);
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (quo > lim) begin
          quo = lim;
          sat = 1'b1;
        end
        elems[i*3+j] = neg ? m3inv_pkg::OUT_W'(-quo) : m3inv_pkg::OUT_W'(quo);
      end
    end
    r.inv00 = elems[0]; r.inv01 = elems[1]; r.inv02 = elems[2];
    r.inv10 = elems[3]; r.inv11 = elems[4]; r.inv12 = elems[5];
    r.inv20 = elems[6]; r.inv21 = elems[7]; r.inv22 = elems[8];
    r.saturated = sat;
    return r;
  endfunction

  // Check each result against the oldest expected inverse.
  always @(posedge clk) begin
    m3inv_pkg::res_t exp_r;
    if (!rst && done) begin
      if (expected_inverses.size() == 0) begin
        failed = 1'b1;
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected result %h", inv);
      end else begin
        exp_r = expected_inverses.pop_front();
        if (inv !== exp_r) begin
          failed = 1'b1;
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Mismatch: expected %h actual %h", exp_r, inv);
          end
        end
      end
    end
  end

  // Directed rows; a known result is given where it is obvious.
  typedef struct {
    m3inv_pkg::req_t m;
    bit              known;
    m3inv_pkg::res_t r;
  } directed_row_t;

  directed_row_t directed_rows[$];

  function automatic m3inv_pkg::req_t diag(logic [m3inv_pkg::FIELD_W-1:0] d0,
                                           logic [m3inv_pkg::FIELD_W-1:0] d1,
                                           logic [m3inv_pkg::FIELD_W-1:0] d2);
    m3inv_pkg::req_t m;
    m = '0;
    m.a00 = d0; m.a11 = d1; m.a22 = d2;
    return m;
  endfunction

  function automatic m3inv_pkg::req_t random_matrix(int mode);
    logic [159:0]    bits;
    m3inv_pkg::req_t m;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
    m = bits[$bits(m3inv_pkg::req_t)-1:0];
    if (mode == 1) begin
      // Small values, with a wider range on the diagonal than off it.
      m.a00 = 16'($urandom_range(0, 2047) - 1024);
      m.a01 = 16'($urandom_range(0, 511) - 256);
      m.a02 = 16'($urandom_range(0, 511) - 256);
      m.a10 = 16'($urandom_range(0, 511) - 256);
      m.a11 = 16'($urandom_range(0, 2047) - 1024);
      m.a12 = 16'($urandom_range(0, 511) - 256);
      m.a20 = 16'($urandom_range(0, 511) - 256);
      m.a21 = 16'($urandom_range(0, 511) - 256);
      m.a22 = 16'($urandom_range(0, 2047) - 1024);
    end else if (mode == 2) begin
      // Row 2 copies row 0, so the matrix is singular.
      m.a20 = m.a00; m.a21 = m.a01; m.a22 = m.a02;
    end
    return m;
  endfunction

  // Start stays high after the request so that requests can follow back to back.
  task automatic send_request(m3inv_pkg::req_t m, bit known, m3inv_pkg::res_t r);
    start <= 1'b1;
    mat   <= m;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_inverses.push_back(known ? r : invert_matrix(m));
  endtask

  task automatic random_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  initial begin
    directed_row_t   row;
    m3inv_pkg::res_t one_r;
    int              wait_cycles;
    failed = 1'b0;
    mismatch_count = 0;
    rst   = 1'b1;
    start = 1'b0;
    mat   = '0;

    // Identity gives 1.0 on the diagonal; all zeros is singular.
    one_r = '0;
    one_r.inv00 = 32'h0001_0000; one_r.inv11 = 32'h0001_0000; one_r.inv22 = 32'h0001_0000;
    row = '{diag(16'h0100, 16'h0100, 16'h0100), 1'b1, one_r};
    directed_rows.push_back(row);
    one_r = '0;
    one_r.singular = 1'b1;
    row = '{'0, 1'b1, one_r};
    directed_rows.push_back(row);
    row = '{m3inv_pkg::req_t'({9{16'hFFFF}}), 1'b1, one_r};
    directed_rows.push_back(row);
    row = '{m3inv_pkg::req_t'({9{16'h7FFF}}), 1'b1, one_r};
    directed_rows.push_back(row);
    // Unit-determinant shear with a large off-diagonal saturates positive and negative.
    one_r = '0;
    one_r.inv00 = 32'h0100_0000; one_r.inv11 = 32'h0100_0000; one_r.inv22 = 32'h0100_0000;
    one_r.inv01 = 32'h7FFF_FFFF;
    one_r.saturated = 1'b1;
    row = '{m3inv_pkg::req_t'({16'h0001, 16'hFF00, 16'h0000, 16'h0000, 16'h0001, 16'h0000,
                               16'h0000, 16'h0000, 16'h0001}), 1'b1, one_r};
    directed_rows.push_back(row);
    one_r.inv01 = 32'h8000_0000;
    row = '{m3inv_pkg::req_t'({16'h0001, 16'h0100, 16'h0000, 16'h0000, 16'h0001, 16'h0000,
                               16'h0000, 16'h0000, 16'h0001}), 1'b1, one_r};
    directed_rows.push_back(row);
    // Remaining rows are predicted.
    row = '{diag(16'h8000, 16'h8000, 16'h8000), 1'b0, '0};
    directed_rows.push_back(row);
    row = '{diag(16'h7FFF, 16'h8000, 16'h7FFF), 1'b0, '0};
    directed_rows.push_back(row);
    row = '{diag(16'h0080, 16'hFF80, 16'h0200), 1'b0, '0};
    directed_rows.push_back(row);
    // Exactly -2^31 in row 0 column 1 is reached without clipping.
    row = '{m3inv_pkg::req_t'({16'h0001, 16'h0080, 16'h0000, 16'h0000, 16'h0001, 16'h0000,
                               16'h0000, 16'h0000, 16'h0001}), 1'b0, '0};
    directed_rows.push_back(row);
    row = '{m3inv_pkg::req_t'({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                               16'h0001, 16'h0000, 16'h7FFF}), 1'b0, '0};
    directed_rows.push_back(row);
    row = '{m3inv_pkg::req_t'({16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0100,
                               16'h0100, 16'h0000, 16'h0000}), 1'b0, '0};
    directed_rows.push_back(row);
    row = '{m3inv_pkg::req_t'({16'h0200, 16'h0100, 16'h0000, 16'h0100, 16'h0300, 16'h0100,
                               16'h0000, 16'h0100, 16'h0400}), 1'b0, '0};
    directed_rows.push_back(row);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].m, directed_rows[i].known, directed_rows[i].r);
      if (i % 4 == 0) random_gap();
    end

    // Random part, with one full drain in the middle.
    for (int i = 0; i < N_RANDOM; i++) begin
      int pick;
      pick = $urandom_range(0, 9);
      send_request(random_matrix(pick < 6 ? 1 : (pick < 8 ? 0 : 2)), 1'b0, '0);
      if (i == N_RANDOM / 2) begin
        start <= 1'b0;
        while (expected_inverses.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 2) == 0) random_gap();
    end
    start <= 1'b0;

    wait_cycles = 0;
    while (expected_inverses.size() != 0 && wait_cycles < 100 * PIPE_DEPTH) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (PIPE_DEPTH + 5) @(posedge clk);
    if (!failed && expected_inverses.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
